>>> design/k_weighting_iir_filter_unit_assert.svh
// assertion macros for the k-weighting filter unit
// included by the top level; expects clk_i and rst_ni in scope
`ifndef K_WEIGHTING_IIR_FILTER_UNIT_ASSERT_SVH
`define K_WEIGHTING_IIR_FILTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define KWF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kwf assertion failed");
`define KWF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kwf assertion failed");
`else
`define KWF_ASSERT_IMP(lbl, ante, cons)
`define KWF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/kwf_pkg.sv
// shared types and constants for the k-weighting filter unit
// used by kwf_mac and k_weighting_iir_filter_unit
package kwf_pkg;

  localparam int CoefW    = 32;
  localparam int WordW    = 48;
  localparam int Frac     = 26;
  localparam int SampleW  = 24;
  localparam int ChanW    = 3;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;
  localparam int Taps     = 4;
  localparam int NumCoef  = 2 * Taps + 1;
  localparam int CoefIdxW = 4;
  localparam int DefChannels = 8;

  // multiplier operand: either the signed upper word part or the unsigned fraction
  localparam int OpW     = Frac + 1;
  localparam int ProdW   = CoefW + OpW;
  localparam int HiAccW  = 57;
  localparam int LoAccW  = 61;
  localparam int RndW    = LoAccW - Frac;
  localparam int TotW    = 58;
  localparam int DiffW   = TotW + 1;
  localparam int YsW     = TotW - Frac;

  localparam logic [CfgIdxW-1:0] CfgB0B1 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgB2B3 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgB4A1 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgA2A3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgA4   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FB_MAC,
    ST_FB_RND,
    ST_FB_SUM,
    ST_FB_W,
    ST_FF_MAC,
    ST_FF_RND,
    ST_FF_SUM,
    ST_FF_Y,
    ST_DONE
  } kwf_state_e;

  typedef struct packed {
    logic clr;  // clear both accumulators
    logic mul;  // issue one product
    logic lo;   // product goes to the fraction accumulator
    logic rnd;  // round the fraction accumulator
    logic ff;   // feedforward rounding point
    logic sum;  // fold rounded fraction into the integer part
  } kwf_mac_ctl_t;

endpackage

>>> design/kwf_mac.sv
// shared multiply-accumulate unit: one 32x27 product per cycle, split accumulators,
// rounding and final sum; depends on kwf_pkg
module kwf_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kwf_pkg::kwf_mac_ctl_t               ctl_i,
  input  logic signed [kwf_pkg::CoefW-1:0]    coef_i,
  input  logic signed [kwf_pkg::OpW-1:0]      opnd_i,
  output logic signed [kwf_pkg::TotW-1:0]     tot_o
);
  import kwf_pkg::*;

  localparam logic signed [LoAccW-1:0] FbRnd = LoAccW'(1) << (Frac - 1);
  localparam logic signed [LoAccW-1:0] FfRnd = LoAccW'(1) << (2 * Frac - 1);

  logic signed [ProdW-1:0]  mul_res;
  logic signed [ProdW-1:0]  prod_q;
  logic                     prod_vld_q;
  logic                     prod_lo_q;
  logic signed [HiAccW-1:0] acc_hi_q;
  logic signed [LoAccW-1:0] acc_lo_q;
  logic signed [LoAccW-1:0] rnd_sum;
  logic signed [RndW-1:0]   rnd_d;
  logic signed [RndW-1:0]   rnd_q;
  logic signed [TotW-1:0]   tot_d;
  logic signed [TotW-1:0]   tot_q;

  assign mul_res = coef_i * opnd_i;
  assign rnd_sum = acc_lo_q + (ctl_i.ff ? FfRnd : FbRnd);
  assign rnd_d   = RndW'(rnd_sum >>> Frac);
  assign tot_d   = TotW'(acc_hi_q) + TotW'(rnd_q);
  assign tot_o   = tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.mul;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_res;
    prod_lo_q <= ctl_i.lo;
    if (ctl_i.clr) begin
      acc_hi_q <= '0;
      acc_lo_q <= '0;
    end else if (prod_vld_q) begin
      if (prod_lo_q) begin
        acc_lo_q <= acc_lo_q + LoAccW'(prod_q);
      end else begin
        // upper-part products fit well inside the narrower accumulator
        acc_hi_q <= acc_hi_q + HiAccW'(prod_q);
      end
    end
    if (ctl_i.rnd) begin
      rnd_q <= rnd_d;
    end
    if (ctl_i.sum) begin
      tot_q <= tot_d;
    end
  end

endmodule

>>> design/k_weighting_iir_filter_unit.sv
// k-weighting filter unit: one input beat at a time; in_stall_o holds off the next beat
// until the result has gone to the output register. a channel beyond the channel count
// skips the filter and gets a zero result. 8 feedback and 10 feedforward products share
// the single multiplier in kwf_mac, with history load, rounding and saturation steps.
// reset clears coefficients and per-channel history valid bits, so all history
// reads as zero right away; no clearing pass. a result may wait while the next beat runs.
`include "k_weighting_iir_filter_unit_assert.svh"
module k_weighting_iir_filter_unit #(
  parameter int CHANNELS = kwf_pkg::DefChannels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [kwf_pkg::SampleW-1:0]   sample_in_i,
  input  logic        [kwf_pkg::ChanW-1:0]     channel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [kwf_pkg::SampleW-1:0]   sample_out_o,
  output logic        [kwf_pkg::ChanW-1:0]     channel_out_o,
  input  logic                                 cfg_we_i,
  input  logic        [kwf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic        [kwf_pkg::CfgW-1:0]      cfg_wdata_i
);
  import kwf_pkg::*;

  localparam int Depth = CHANNELS * Taps;
  localparam int AddrW = $clog2(Depth);
  localparam int RowW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CntW  = 4;
  localparam logic [CntW-1:0] LoadLast = CntW'(Taps);
  localparam logic [CntW-1:0] FbLast   = CntW'(2 * Taps);
  localparam logic [CntW-1:0] FfLast   = CntW'(2 * Taps + 2);
  localparam logic [CntW-1:0] WbLast   = CntW'(Taps);
  localparam logic signed [WordW-1:0]   WMax = {1'b0, {(WordW - 1){1'b1}}};
  localparam logic signed [WordW-1:0]   WMin = {1'b1, {(WordW - 1){1'b0}}};
  localparam logic signed [SampleW-1:0] YMax = {1'b0, {(SampleW - 1){1'b1}}};
  localparam logic signed [SampleW-1:0] YMin = {1'b1, {(SampleW - 1){1'b0}}};

  kwf_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [CfgW-1:0]  coef_b0_b1_q, coef_b2_b3_q, coef_b4_a1_q, coef_a2_a3_q;
  logic [CoefW-1:0] coef_a4_q;
  logic [CoefW-1:0] coef_a [NumCoef];

  logic signed [SampleW-1:0] x_q;
  logic [ChanW-1:0]          ch_q;
  logic [WordW-1:0]          w_q [Taps + 1];
  logic signed [SampleW-1:0] y_q;

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rd_q;
  logic [AddrW-1:0] mem_addr;
  logic             mem_we;
  logic [CHANNELS-1:0] row_vld_q;
  logic [RowW-1:0]  row_idx;

  logic in_acc, in_range, out_load;
  logic out_vld_q;
  logic signed [SampleW-1:0] sample_out_q;
  logic [ChanW-1:0]          chan_out_q;

  kwf_mac_ctl_t mac_ctl;
  logic [2:0]   tap, widx;
  logic [CoefIdxW-1:0] cidx;
  logic [WordW-1:0]    wsel;
  logic signed [OpW-1:0]   opnd;
  logic signed [TotW-1:0]  tot;
  logic signed [DiffW-1:0] diff;
  logic signed [WordW-1:0] w0_sat;
  logic signed [YsW-1:0]   ys;
  logic signed [SampleW-1:0] y_sat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = int'(channel_i) < CHANNELS;
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  assign out_valid_o   = out_vld_q;
  assign sample_out_o  = sample_out_q;
  assign channel_out_o = chan_out_q;

  // coefficient order: b0..b4 then a1..a4
  assign coef_a[0] = coef_b0_b1_q[CoefW-1:0];
  assign coef_a[1] = coef_b0_b1_q[CfgW-1:CoefW];
  assign coef_a[2] = coef_b2_b3_q[CoefW-1:0];
  assign coef_a[3] = coef_b2_b3_q[CfgW-1:CoefW];
  assign coef_a[4] = coef_b4_a1_q[CoefW-1:0];
  assign coef_a[5] = coef_b4_a1_q[CfgW-1:CoefW];
  assign coef_a[6] = coef_a2_a3_q[CoefW-1:0];
  assign coef_a[7] = coef_a2_a3_q[CfgW-1:CoefW];
  assign coef_a[8] = coef_a4_q;

  assign mem_addr = AddrW'({ch_q, cnt_q[1:0]});
  assign row_idx  = RowW'(ch_q);

  // w_q[0] holds the new word, w_q[1..4] the stored history newest first
  assign tap  = cnt_q[3:1];
  assign widx = (state_q == ST_FB_MAC) ? tap + 3'd1 : tap;
  assign cidx = (state_q == ST_FB_MAC) ? CoefIdxW'(tap) + CoefIdxW'(Taps + 1)
                                       : CoefIdxW'(tap);
  assign wsel = w_q[widx];
  assign opnd = cnt_q[0] ? OpW'({1'b0, wsel[Frac-1:0]})
                         : {{(OpW - WordW + Frac){wsel[WordW-1]}}, wsel[WordW-1:Frac]};

  kwf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (coef_a[cidx]),
    .opnd_i (opnd),
    .tot_o  (tot)
  );

  // new word: x scaled up minus rounded feedback, saturated to the word range
  assign diff = (DiffW'(x_q) <<< Frac) - DiffW'(tot);
  always_comb begin
    if (diff[DiffW-1:WordW-1] != {(DiffW - WordW + 1){diff[DiffW-1]}}) begin
      w0_sat = diff[DiffW-1] ? WMin : WMax;
    end else begin
      w0_sat = diff[WordW-1:0];
    end
  end

  assign ys = YsW'(tot >>> Frac);
  always_comb begin
    if (ys[YsW-1:SampleW-1] != {(YsW - SampleW + 1){ys[YsW-1]}}) begin
      y_sat = ys[YsW-1] ? YMin : YMax;
    end else begin
      y_sat = ys[SampleW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mac_ctl = '0;
    mem_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          state_d = in_range ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LoadLast) begin
          cnt_d   = '0;
          state_d = ST_FB_MAC;
        end
      end
      ST_FB_MAC: begin
        mac_ctl.clr = (cnt_q == '0);
        mac_ctl.mul = (cnt_q < FbLast);
        mac_ctl.lo  = cnt_q[0];
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == FbLast) begin
          cnt_d   = '0;
          state_d = ST_FB_RND;
        end
      end
      ST_FB_RND: begin
        mac_ctl.rnd = 1'b1;
        state_d     = ST_FB_SUM;
      end
      ST_FB_SUM: begin
        mac_ctl.sum = 1'b1;
        state_d     = ST_FB_W;
      end
      ST_FB_W: begin
        state_d = ST_FF_MAC;
      end
      ST_FF_MAC: begin
        mac_ctl.clr = (cnt_q == '0);
        mac_ctl.mul = (cnt_q < FfLast);
        mac_ctl.lo  = cnt_q[0];
        // shifted history goes back while the feedforward products run
        mem_we      = (cnt_q < WbLast);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == FfLast) begin
          cnt_d   = '0;
          state_d = ST_FF_RND;
        end
      end
      ST_FF_RND: begin
        mac_ctl.rnd = 1'b1;
        mac_ctl.ff  = 1'b1;
        state_d     = ST_FF_SUM;
      end
      ST_FF_SUM: begin
        mac_ctl.sum = 1'b1;
        state_d     = ST_FF_Y;
      end
      ST_FF_Y: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      out_vld_q    <= 1'b0;
      row_vld_q    <= '0;
      coef_b0_b1_q <= '0;
      coef_b2_b3_q <= '0;
      coef_b4_a1_q <= '0;
      coef_a2_a3_q <= '0;
      coef_a4_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if ((state_q == ST_FF_MAC) && (cnt_q == '0)) begin
        row_vld_q[row_idx] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgB0B1: coef_b0_b1_q <= cfg_wdata_i;
          CfgB2B3: coef_b2_b3_q <= cfg_wdata_i;
          CfgB4A1: coef_b4_a1_q <= cfg_wdata_i;
          CfgA2A3: coef_a2_a3_q <= cfg_wdata_i;
          CfgA4:   coef_a4_q    <= cfg_wdata_i[CoefW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= sample_in_i;
      ch_q <= channel_i;
      if (!in_range) begin
        y_q <= '0;
      end
    end
    if ((state_q == ST_LOAD) && (cnt_q != '0)) begin
      w_q[cnt_q[2:0]] <= row_vld_q[row_idx] ? rd_q : '0;
    end
    if (state_q == ST_FB_W) begin
      w_q[0] <= w0_sat;
    end
    if (state_q == ST_FF_Y) begin
      y_q <= y_sat;
    end
    if (out_load) begin
      sample_out_q <= y_q;
      chan_out_q   <= ch_q;
    end
  end

  // history store: one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= w_q[cnt_q[2:0]];
    end
    rd_q <= mem_q[mem_addr];
  end

  `KWF_ASSERT_NXT(a_done_pushes_beat, out_load, out_vld_q && (state_q == ST_IDLE))
  `KWF_ASSERT_NXT(a_bad_chan_skips, in_acc && !in_range, (state_q == ST_DONE) && (y_q == '0))
  `KWF_ASSERT_NXT(a_rows_only_fill, 1'b1, (row_vld_q & $past(row_vld_q)) == $past(row_vld_q))

endmodule
